### sv/dwpid_pkg.sv
package dwpid_pkg;

   localparam int DUTY_MAX = 8191;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam int GAIN_W = 24;
   localparam int DPU_W = 16;
   localparam int SPEED_W = 24;
   localparam int COUNT_W = 16;
   localparam int TGT_W = 26;
   localparam int ERR_W = 27;
   localparam int DIFF_W = 28;
   localparam int INTEG_W = 40;
   localparam int PTERM_W = 35;
   localparam int DTERM_W = 36;
   localparam int SUM_W = 42;
   localparam int DUTY_W = 13;

   // shared multiplier: signed a by signed b, unsigned operands zero extended
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_SPEED_COUNT  = 3'd3,
      CSR_DRIVE_LIMIT  = 3'd4,
      CSR_DUTY_UNIT    = 3'd5,
      CSR_HALF_TRACK   = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_COMMAND = 1'b0,
      OP_TICK    = 1'b1
   } operation_type;

   typedef struct packed {
      logic               operation;
      logic signed [23:0] linear_speed;
      logic signed [23:0] angular_speed;
      logic signed [15:0] count_left;
      logic signed [15:0] count_right;
   } req_payload_type;

   typedef struct packed {
      logic [12:0]        left_forward_duty;
      logic [12:0]        left_reverse_duty;
      logic [12:0]        right_forward_duty;
      logic [12:0]        right_reverse_duty;
      logic signed [23:0] measured_left;
      logic signed [23:0] measured_right;
      logic               in_stop_mode;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_TURN,
      S_TARGET,
      S_MEAS_L,
      S_MEAS_R,
      S_MEAS_WB,
      S_ERR,
      S_DIFF,
      S_MUL_I,
      S_MUL_D,
      S_D_WB,
      S_SUM,
      S_CLAMP,
      S_DUTY_MUL,
      S_DUTY_WB,
      S_STOP,
      S_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_TURN,
      MUL_MEAS_L,
      MUL_MEAS_R,
      MUL_P,
      MUL_I,
      MUL_D,
      MUL_DUTY
   } mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_TARGET,
      WB_MEAS,
      WB_ERR,
      WB_DIFF,
      WB_P,
      WB_I,
      WB_D,
      WB_SUM,
      WB_CLAMP,
      WB_DUTY,
      WB_STOP
   } wb_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
      logic        wheel;
      logic        out_load;
   } dp_cmd_type;

endpackage

### sv/dwpid_ctrl.sv
module dwpid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   was_stop,
   output dwpid_pkg::dp_cmd_type  cmd
);

   dwpid_pkg::state_type state_ff, state_in;
   logic wheel_ff, wheel_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic out_free;

   assign accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dwpid_pkg::S_IDLE;
         wheel_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wheel_ff <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dwpid_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (req_op == dwpid_pkg::OP_TICK) ? dwpid_pkg::S_MEAS_L
                                                          : dwpid_pkg::S_TURN;
            end
         end
         dwpid_pkg::S_TURN:     state_in = dwpid_pkg::S_TARGET;
         dwpid_pkg::S_TARGET:   state_in = dwpid_pkg::S_IDLE;
         dwpid_pkg::S_MEAS_L:   state_in = dwpid_pkg::S_MEAS_R;
         dwpid_pkg::S_MEAS_R:   state_in = dwpid_pkg::S_MEAS_WB;
         dwpid_pkg::S_MEAS_WB:  state_in = was_stop ? dwpid_pkg::S_STOP : dwpid_pkg::S_ERR;
         dwpid_pkg::S_ERR:      state_in = dwpid_pkg::S_DIFF;
         dwpid_pkg::S_DIFF:     state_in = dwpid_pkg::S_MUL_I;
         dwpid_pkg::S_MUL_I:    state_in = dwpid_pkg::S_MUL_D;
         dwpid_pkg::S_MUL_D:    state_in = dwpid_pkg::S_D_WB;
         dwpid_pkg::S_D_WB:     state_in = dwpid_pkg::S_SUM;
         dwpid_pkg::S_SUM:      state_in = dwpid_pkg::S_CLAMP;
         dwpid_pkg::S_CLAMP:    state_in = dwpid_pkg::S_DUTY_MUL;
         dwpid_pkg::S_DUTY_MUL: state_in = dwpid_pkg::S_DUTY_WB;
         dwpid_pkg::S_DUTY_WB:  state_in = wheel_ff ? dwpid_pkg::S_OUT : dwpid_pkg::S_ERR;
         dwpid_pkg::S_STOP:     state_in = dwpid_pkg::S_OUT;
         dwpid_pkg::S_OUT: begin
            if (out_free) begin
               state_in = dwpid_pkg::S_IDLE;
            end
         end
         default:               state_in = dwpid_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = (state_ff == dwpid_pkg::S_IDLE);
      cmd.load = 1'b0;
      cmd.mul_sel = dwpid_pkg::MUL_NONE;
      cmd.wb_sel = dwpid_pkg::WB_NONE;
      cmd.wheel = wheel_ff;
      cmd.out_load = 1'b0;
      wheel_in = wheel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         dwpid_pkg::S_IDLE:     cmd.load = accept;
         dwpid_pkg::S_TURN:     cmd.mul_sel = dwpid_pkg::MUL_TURN;
         dwpid_pkg::S_TARGET:   cmd.wb_sel = dwpid_pkg::WB_TARGET;
         dwpid_pkg::S_MEAS_L:   cmd.mul_sel = dwpid_pkg::MUL_MEAS_L;
         dwpid_pkg::S_MEAS_R: begin
            cmd.mul_sel = dwpid_pkg::MUL_MEAS_R;
            cmd.wb_sel = dwpid_pkg::WB_MEAS;
            cmd.wheel = 1'b0;
         end
         dwpid_pkg::S_MEAS_WB: begin
            cmd.wb_sel = dwpid_pkg::WB_MEAS;
            cmd.wheel = 1'b1;
            wheel_in = 1'b0;
         end
         dwpid_pkg::S_ERR:      cmd.wb_sel = dwpid_pkg::WB_ERR;
         dwpid_pkg::S_DIFF: begin
            cmd.wb_sel = dwpid_pkg::WB_DIFF;
            cmd.mul_sel = dwpid_pkg::MUL_P;
         end
         dwpid_pkg::S_MUL_I: begin
            cmd.mul_sel = dwpid_pkg::MUL_I;
            cmd.wb_sel = dwpid_pkg::WB_P;
         end
         dwpid_pkg::S_MUL_D: begin
            cmd.mul_sel = dwpid_pkg::MUL_D;
            cmd.wb_sel = dwpid_pkg::WB_I;
         end
         dwpid_pkg::S_D_WB:     cmd.wb_sel = dwpid_pkg::WB_D;
         dwpid_pkg::S_SUM:      cmd.wb_sel = dwpid_pkg::WB_SUM;
         dwpid_pkg::S_CLAMP:    cmd.wb_sel = dwpid_pkg::WB_CLAMP;
         dwpid_pkg::S_DUTY_MUL: cmd.mul_sel = dwpid_pkg::MUL_DUTY;
         dwpid_pkg::S_DUTY_WB: begin
            cmd.wb_sel = dwpid_pkg::WB_DUTY;
            wheel_in = !wheel_ff;
         end
         dwpid_pkg::S_STOP:     cmd.wb_sel = dwpid_pkg::WB_STOP;
         dwpid_pkg::S_OUT: begin
            cmd.out_load = out_free;
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/dwpid_dp.sv
module dwpid_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [2:0]                  csr_index,
   input  logic [23:0]                 csr_data,
   input  dwpid_pkg::req_payload_type  req_payload,
   input  dwpid_pkg::dp_cmd_type       cmd,
   output logic                        was_stop,
   output dwpid_pkg::rsp_payload_type  rsp_payload
);

   // configuration
   logic [dwpid_pkg::GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [dwpid_pkg::GAIN_W-1:0] speed_count_ff, drive_limit_ff;
   logic [dwpid_pkg::DPU_W-1:0]  duty_unit_ff, half_track_ff;

   // controller state
   logic signed [dwpid_pkg::TGT_W-1:0]   target_ff [2];
   logic signed [dwpid_pkg::INTEG_W-1:0] integ_ff [2];
   logic signed [dwpid_pkg::ERR_W-1:0]   last_ff [2];
   logic                                 stopped_ff;

   // working registers
   dwpid_pkg::req_payload_type           item_ff;
   logic                                 was_stop_ff;
   logic signed [dwpid_pkg::SPEED_W-1:0] meas_ff [2];
   logic signed [dwpid_pkg::ERR_W-1:0]   err_ff;
   logic signed [dwpid_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [dwpid_pkg::PTERM_W-1:0] p_ff;
   logic signed [dwpid_pkg::DTERM_W-1:0] d_ff;
   logic signed [dwpid_pkg::SUM_W-1:0]   sum_ff;
   logic [dwpid_pkg::GAIN_W-1:0]         mag_ff;
   logic                                 pos_ff;
   logic [dwpid_pkg::DUTY_W-1:0]         fwd_ff [2];
   logic [dwpid_pkg::DUTY_W-1:0]         rev_ff [2];
   dwpid_pkg::rsp_payload_type           rsp_ff;

   logic signed [dwpid_pkg::MUL_A_W-1:0] mul_a;
   logic signed [dwpid_pkg::MUL_B_W-1:0] mul_b;
   logic signed [dwpid_pkg::MUL_P_W-1:0] prod_ff;

   logic signed [23:0]                    lin_c, turn_c;
   logic signed [31:0]                    meas_raw;
   logic signed [dwpid_pkg::SPEED_W-1:0]  meas_sat;
   logic signed [dwpid_pkg::PTERM_W-1:0]  inc_c;
   logic signed [dwpid_pkg::INTEG_W:0]    integ_sum;
   logic signed [dwpid_pkg::INTEG_W-1:0]  integ_sat;
   logic signed [dwpid_pkg::SUM_W-1:0]    lim_c, abs_c;
   logic [dwpid_pkg::GAIN_W-1:0]          mag_c;
   logic [23:0]                           duty_raw, duty_sat;
   logic signed [dwpid_pkg::COUNT_W:0]    count_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= 24'd65536;
         integ_gain_ff <= 24'd786432;
         deriv_gain_ff <= 24'd598016;
         speed_count_ff <= 24'd8236;
         drive_limit_ff <= 24'd131072;
         duty_unit_ff <= 16'd4000;
         half_track_ff <= 16'd14746;
      end else if (csr_write) begin
         unique case (csr_index)
            dwpid_pkg::CSR_PROP_GAIN:   prop_gain_ff <= csr_data;
            dwpid_pkg::CSR_INTEG_GAIN:  integ_gain_ff <= csr_data;
            dwpid_pkg::CSR_DERIV_GAIN:  deriv_gain_ff <= csr_data;
            dwpid_pkg::CSR_SPEED_COUNT: speed_count_ff <= csr_data;
            dwpid_pkg::CSR_DRIVE_LIMIT: drive_limit_ff <= csr_data;
            dwpid_pkg::CSR_DUTY_UNIT:   duty_unit_ff <= csr_data[15:0];
            dwpid_pkg::CSR_HALF_TRACK:  half_track_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         dwpid_pkg::MUL_TURN: begin
            mul_a = dwpid_pkg::MUL_A_W'($signed(item_ff.angular_speed));
            mul_b = $signed({9'd0, half_track_ff});
         end
         dwpid_pkg::MUL_MEAS_L: begin
            mul_a = dwpid_pkg::MUL_A_W'($signed(item_ff.count_left));
            mul_b = $signed({1'b0, speed_count_ff});
         end
         dwpid_pkg::MUL_MEAS_R: begin
            mul_a = dwpid_pkg::MUL_A_W'($signed(item_ff.count_right));
            mul_b = $signed({1'b0, speed_count_ff});
         end
         dwpid_pkg::MUL_P: begin
            mul_a = dwpid_pkg::MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, prop_gain_ff});
         end
         dwpid_pkg::MUL_I: begin
            mul_a = dwpid_pkg::MUL_A_W'(err_ff);
            mul_b = $signed({1'b0, integ_gain_ff});
         end
         dwpid_pkg::MUL_D: begin
            mul_a = diff_ff;
            mul_b = $signed({1'b0, deriv_gain_ff});
         end
         dwpid_pkg::MUL_DUTY: begin
            mul_a = $signed({4'd0, mag_ff});
            mul_b = $signed({9'd0, duty_unit_ff});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= dwpid_pkg::MUL_P_W'(mul_a) * dwpid_pkg::MUL_P_W'(mul_b);
   end

   // writeback arithmetic, products narrowed by arithmetic shift (floor)
   always_comb begin
      lin_c = $signed(item_ff.linear_speed);
      turn_c = $signed(prod_ff[39:16]);

      meas_raw = $signed(prod_ff[39:8]);
      if (meas_raw > 32'sd8388607) begin
         meas_sat = 24'sh7FFFFF;
      end else if (meas_raw < -32'sd8388608) begin
         meas_sat = 24'sh800000;
      end else begin
         meas_sat = meas_raw[23:0];
      end

      inc_c = $signed(prod_ff[50:16]);
      integ_sum = (dwpid_pkg::INTEG_W+1)'(integ_ff[cmd.wheel])
                + (dwpid_pkg::INTEG_W+1)'(inc_c);
      if (integ_sum[dwpid_pkg::INTEG_W] != integ_sum[dwpid_pkg::INTEG_W-1]) begin
         integ_sat = integ_sum[dwpid_pkg::INTEG_W]
                   ? {1'b1, {(dwpid_pkg::INTEG_W-1){1'b0}}}
                   : {1'b0, {(dwpid_pkg::INTEG_W-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[dwpid_pkg::INTEG_W-1:0];
      end

      lim_c = $signed({18'd0, drive_limit_ff});
      abs_c = (sum_ff < 0) ? -sum_ff : sum_ff;
      if (sum_ff > lim_c || sum_ff < -lim_c) begin
         mag_c = drive_limit_ff;
      end else begin
         mag_c = abs_c[dwpid_pkg::GAIN_W-1:0];
      end

      duty_raw = prod_ff[39:16];
      duty_sat = (duty_raw > 24'(dwpid_pkg::DUTY_MAX)) ? 24'(dwpid_pkg::DUTY_MAX) : duty_raw;

      count_sum = (dwpid_pkg::COUNT_W+1)'($signed(item_ff.count_left))
                + (dwpid_pkg::COUNT_W+1)'($signed(item_ff.count_right));
   end

   // state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff[0] <= '0;
         target_ff[1] <= '0;
         integ_ff[0] <= '0;
         integ_ff[1] <= '0;
         last_ff[0] <= '0;
         last_ff[1] <= '0;
         stopped_ff <= 1'b0;
      end else begin
         case (cmd.wb_sel)
            dwpid_pkg::WB_TARGET: begin
               target_ff[0] <= dwpid_pkg::TGT_W'(lin_c) - dwpid_pkg::TGT_W'(turn_c);
               target_ff[1] <= dwpid_pkg::TGT_W'(lin_c) + dwpid_pkg::TGT_W'(turn_c);
               stopped_ff <= (lin_c == 24'sd0);
            end
            dwpid_pkg::WB_I: begin
               integ_ff[cmd.wheel] <= integ_sat;
               last_ff[cmd.wheel] <= err_ff;
            end
            dwpid_pkg::WB_STOP: begin
               integ_ff[0] <= '0;
               integ_ff[1] <= '0;
               last_ff[0] <= '0;
               last_ff[1] <= '0;
               if (count_sum == '0) begin
                  stopped_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_payload;
         was_stop_ff <= stopped_ff;
         fwd_ff[0] <= '0;
         fwd_ff[1] <= '0;
         rev_ff[0] <= '0;
         rev_ff[1] <= '0;
      end
      case (cmd.wb_sel)
         dwpid_pkg::WB_MEAS:  meas_ff[cmd.wheel] <= meas_sat;
         dwpid_pkg::WB_ERR: begin
            err_ff <= dwpid_pkg::ERR_W'(target_ff[cmd.wheel])
                    - dwpid_pkg::ERR_W'(meas_ff[cmd.wheel]);
         end
         dwpid_pkg::WB_DIFF: begin
            diff_ff <= dwpid_pkg::DIFF_W'(err_ff) - dwpid_pkg::DIFF_W'(last_ff[cmd.wheel]);
         end
         dwpid_pkg::WB_P:     p_ff <= $signed(prod_ff[50:16]);
         dwpid_pkg::WB_D:     d_ff <= $signed(prod_ff[51:16]);
         dwpid_pkg::WB_SUM: begin
            sum_ff <= dwpid_pkg::SUM_W'(p_ff) + dwpid_pkg::SUM_W'(integ_ff[cmd.wheel])
                    + dwpid_pkg::SUM_W'(d_ff);
         end
         dwpid_pkg::WB_CLAMP: begin
            mag_ff <= mag_c;
            pos_ff <= (sum_ff > 0);
         end
         dwpid_pkg::WB_DUTY: begin
            fwd_ff[cmd.wheel] <= pos_ff ? duty_sat[dwpid_pkg::DUTY_W-1:0] : '0;
            rev_ff[cmd.wheel] <= pos_ff ? '0 : duty_sat[dwpid_pkg::DUTY_W-1:0];
         end
         default: ;
      endcase
      if (cmd.out_load) begin
         rsp_ff.left_forward_duty <= fwd_ff[0];
         rsp_ff.left_reverse_duty <= rev_ff[0];
         rsp_ff.right_forward_duty <= fwd_ff[1];
         rsp_ff.right_reverse_duty <= rev_ff[1];
         rsp_ff.measured_left <= meas_ff[0];
         rsp_ff.measured_right <= meas_ff[1];
         rsp_ff.in_stop_mode <= was_stop_ff;
      end
   end

   assign was_stop = was_stop_ff;
   assign rsp_payload = rsp_ff;

endmodule

### sv/dual_wheel_pid_speed_control.sv
// speed command: ready again after the TURN and TARGET states, no result
// control tick: result valid after the measure, per-wheel PID and output states (PID states skipped in stopped mode),
// next item taken in the cycle after the result register is loaded
// one 28x25 multiplier is shared over ten products per tick, which sets the rate
// synchronous active-high reset loads the register defaults and clears targets,
// integrators, last errors and the stopped flag
module dual_wheel_pid_speed_control (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dwpid_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dwpid_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [23:0]                 csr_data
);

   dwpid_pkg::dp_cmd_type cmd;
   logic was_stop;

   assign csr_ready = 1'b1;

   dwpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .was_stop  (was_stop),
      .cmd       (cmd)
   );

   dwpid_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .was_stop    (was_stop),
      .rsp_payload (rsp_payload)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.in_stop_mode) |->
         (rsp_payload.left_forward_duty == '0 && rsp_payload.left_reverse_duty == '0 &&
          rsp_payload.right_forward_duty == '0 && rsp_payload.right_reverse_duty == '0))
      else $error("nonzero duty on a stopped tick");

   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         !(rsp_payload.left_forward_duty != '0 && rsp_payload.left_reverse_duty != '0) &&
         !(rsp_payload.right_forward_duty != '0 && rsp_payload.right_reverse_duty != '0))
      else $error("wheel driven forward and reverse at once");

endmodule
